@@ rtl/core/etdc_pkg.sv @@
// shared types, codes and constants for the edge triggered decimating capture core
// no dependencies; compiled before the channel interfaces and the core
package etdc_pkg;

    // configuration port
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIM   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

    localparam logic [CFG_W-1:0] LEVEL_RST   = 8'd128;
    localparam logic [CFG_W-1:0] DECIM_RST   = 8'd1;
    localparam logic [CFG_W-1:0] TIMEOUT_RST = 8'd120;

    // geometry defaults
    localparam int CAPTURE_DEPTH_DEF     = 200;
    localparam int FRAMES_PER_STRIDE_DEF = 25;
    localparam int FRAME_BYTES           = 8;
    localparam int BYTE_IDX_W            = 3;

    // command opcodes
    localparam logic OP_ARM   = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FREQ   = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    // capture phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HUNT    = 2'd1;
    localparam logic [1:0] PH_CAPTURE = 2'd2;

    // raw byte to signed code offset
    localparam logic [7:0] CODE_OFFSET = 8'd128;

    typedef struct packed {
        logic       opcode;
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
        logic [7:0] byte_4;
        logic [7:0] byte_5;
        logic [7:0] byte_6;
        logic [7:0] byte_7;
    } etdc_in_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        sample_index;
        logic signed [7:0] sample_code;
        logic [23:0]       frequency_value;
        logic [7:0]        frames_used;
        logic              last;
    } etdc_out_t;

    // samples written per frame for strides below eight
    function automatic logic [3:0] samples_per_frame(input logic [2:0] stride);
        logic [3:0] cnt;
        begin
            case (stride)
                3'd1:    cnt = 4'd8;
                3'd2:    cnt = 4'd4;
                3'd3:    cnt = 4'd2;
                3'd4:    cnt = 4'd2;
                default: cnt = 4'd1;
            endcase
            return cnt;
        end
    endfunction

endpackage

@@ rtl/core/etdc_in_if.sv @@
// command channel: valid/ready handshake carrying an arm command or one adc frame
// depends on etdc_pkg
interface etdc_in_if;
    import etdc_pkg::*;

    logic     valid;
    logic     ready;
    etdc_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/etdc_out_if.sv @@
// result channel: valid/ready handshake carrying one sample, frequency or done item
// depends on etdc_pkg
interface etdc_out_if;
    import etdc_pkg::*;

    logic      valid;
    logic      ready;
    etdc_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/edge_triggered_decimating_capture_core.sv @@
// edge triggered decimating capture core: trigger hunt, stride decimation, result sequencing
// depends on etdc_pkg, etdc_in_if and etdc_out_if
//
// An arm command, which gives no result, starts a hunt for a rising crossing of
// trigger_level over the stream of 8-byte frames; the byte before the first one counts
// as below any level. The hunt scans one byte per cycle; on a crossing it sends the
// bytes from the trigger point at stride m, one per cycle while the result channel
// takes them. After trigger_timeout frames without a crossing the capture starts with
// no pretrigger data. During capture every frame runs through one shared restoring
// divider, one quotient bit per cycle: stride m below 8 divides 8*frames by m for the
// write position, and a second pass gives the fill after the frame; stride 8 and up
// takes the frame count modulo m/8 to pick the frames that write byte 0. Frames whose
// first four bytes are zero send a frequency report instead.
// The command channel is ready only between items; the result register lets the last
// result of one item wait while the next item is taken. Configuration writes are taken
// at any time but belong between items.
module edge_triggered_decimating_capture_core #(
    parameter int CAPTURE_DEPTH     = etdc_pkg::CAPTURE_DEPTH_DEF,
    parameter int FRAMES_PER_STRIDE = etdc_pkg::FRAMES_PER_STRIDE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [etdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [etdc_pkg::CFG_W-1:0]     cfg_data,
    etdc_in_if.sink                        cmd,
    etdc_out_if.source                     result
);
    import etdc_pkg::*;

    // frame counter reaches FRAMES_PER_STRIDE * 255 at most
    localparam int FC_W    = $clog2(FRAMES_PER_STRIDE * 255 + 1);
    // divider covers the frame counter and 8 * (data frames + 1)
    localparam int DIV_W   = (FC_W > 12) ? FC_W : 12;
    localparam int DCNT_W  = $clog2(DIV_W + 1);
    localparam int IDX_W   = DIV_W + 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPTURE_DEPTH - 1);
    localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = BYTE_IDX_W'(FRAME_BYTES - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_HEMIT = 3'd2;
    localparam logic [2:0] ST_DIVA  = 3'd3;
    localparam logic [2:0] ST_DIVB  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // configuration registers
    logic [CFG_W-1:0] level_reg;
    logic [CFG_W-1:0] decim_reg;
    logic [CFG_W-1:0] timeout_reg;

    // capture state
    logic [2:0]            state_reg,      state_next;
    logic [1:0]            phase_reg,      phase_next;
    logic                  prev_valid_reg, prev_valid_next;  // clear means "below any level"
    logic [7:0]            prev_reg,       prev_next;
    logic [7:0]            hunt_reg,       hunt_next;
    logic [3:0]            pre_reg,        pre_next;
    logic [FC_W-1:0]       fc_reg,         fc_next;
    logic [7:0]            df_reg,         df_next;

    // per-frame working registers
    logic [7:0]            frame_reg [FRAME_BYTES];
    logic [7:0]            m_reg,          m_next;
    logic                  freq_reg,       freq_next;
    logic                  small_reg,      small_next;
    logic [BYTE_IDX_W-1:0] ptr_reg,        ptr_next;
    logic [3:0]            cnt_reg,        cnt_next;
    logic [IDX_W-1:0]      idx_reg,        idx_next;
    logic                  stride_reg,     stride_next;
    logic                  done_reg,       done_next;

    // shared restoring divider
    logic [DIV_W-1:0]      div_n_reg,      div_n_next;   // dividend, shifts into quotient
    logic [4:0]            div_r_reg,      div_r_next;
    logic [4:0]            div_d_reg,      div_d_next;
    logic [DCNT_W-1:0]     div_cnt_reg,    div_cnt_next;

    // result register
    logic                  out_valid_reg,  out_valid_next;
    etdc_out_t             out_data_reg,   out_data_next;
    logic                  out_load;

    logic                  cmd_fire;
    logic                  slot_free;
    logic [7:0]            m_eff;
    logic                  frame_is_freq;
    logic [7:0]            cur_byte;
    logic [5:0]            div_trial;
    logic                  div_ge;
    logic [IDX_W-1:0]      q_plus_pre;
    logic [FC_W:0]         fc_plus1;
    logic [FC_W:0]         stride_limit;
    logic                  stride_hit;
    logic                  big_hit;
    logic [IDX_W-1:0]      df_sum;
    logic [IDX_W-1:0]      big_idx;
    logic [IDX_W-1:0]      big_fill;
    logic [8:0]            hunt_ptr_sum;
    logic [8:0]            df_plus1;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    // a result can be loaded when the register is empty or drains this cycle
    assign slot_free = !out_valid_reg || result.ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // zero stride acts as one
    assign m_eff = (decim_reg == '0) ? 8'd1 : decim_reg;

    assign frame_is_freq = (cmd.data.byte_0 == '0) && (cmd.data.byte_1 == '0) &&
                           (cmd.data.byte_2 == '0) && (cmd.data.byte_3 == '0);

    assign cur_byte = frame_reg[ptr_reg];

    // one quotient bit per cycle; remainder stays below the divisor
    assign div_trial = {div_r_reg, div_n_reg[DIV_W-1]};
    assign div_ge    = (div_trial >= {1'b0, div_d_reg});

    assign q_plus_pre   = IDX_W'(div_n_reg) + IDX_W'(pre_reg);
    assign fc_plus1     = {1'b0, fc_reg} + (FC_W+1)'(1);
    assign stride_limit = (FC_W+1)'(FRAMES_PER_STRIDE) * (FC_W+1)'(m_reg);
    assign stride_hit   = (fc_plus1 >= stride_limit);

    // stride eight and up: a non-frequency frame writes when count mod m/8 is zero
    assign big_hit  = !freq_reg && (div_r_reg == '0);
    assign df_sum   = IDX_W'(df_reg) + IDX_W'(big_hit);
    assign big_idx  = IDX_W'(df_reg) + IDX_W'(pre_reg);
    assign big_fill = df_sum + IDX_W'(pre_reg);

    assign hunt_ptr_sum = 9'(ptr_reg) + 9'(m_reg);
    assign df_plus1     = 9'(df_reg) + 9'd1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= LEVEL_RST;
            decim_reg   <= DECIM_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEVEL:   level_reg   <= cfg_data;
                REG_DECIM:   decim_reg   <= cfg_data;
                REG_TIMEOUT: timeout_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        prev_valid_next = prev_valid_reg;
        prev_next       = prev_reg;
        hunt_next       = hunt_reg;
        pre_next        = pre_reg;
        fc_next         = fc_reg;
        df_next         = df_reg;
        m_next          = m_reg;
        freq_next       = freq_reg;
        small_next      = small_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        stride_next     = stride_reg;
        done_next       = done_reg;
        div_n_next      = div_n_reg;
        div_r_next      = div_r_reg;
        div_d_next      = div_d_reg;
        div_cnt_next    = div_cnt_reg;
        out_load        = 1'b0;
        out_data_next   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    m_next = m_eff;
                    if (cmd.data.opcode == OP_ARM)
                    begin
                        phase_next      = PH_HUNT;
                        prev_valid_next = 1'b0;
                        hunt_next       = '0;
                        pre_next        = '0;
                        fc_next         = '0;
                        df_next         = '0;
                    end
                    else if (phase_reg == PH_HUNT)
                    begin
                        if (hunt_reg >= timeout_reg)
                        begin
                            // hunt gives up, capture without pretrigger data
                            phase_next = PH_CAPTURE;
                            fc_next    = '0;
                            df_next    = '0;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    else if (phase_reg == PH_CAPTURE)
                    begin
                        freq_next    = frame_is_freq;
                        small_next   = (m_eff[7:3] == '0);
                        div_r_next   = '0;
                        div_cnt_next = DCNT_W'(DIV_W);
                        if (m_eff[7:3] == '0)
                        begin
                            div_n_next = DIV_W'({df_reg, 3'b000});
                            div_d_next = {2'b00, m_eff[2:0]};
                        end
                        else
                        begin
                            div_n_next = DIV_W'(fc_reg);
                            div_d_next = m_eff[7:3];
                        end
                        state_next = ST_DIVA;
                    end
                end
            end

            ST_SCAN:
            begin
                if (cur_byte >= level_reg && (!prev_valid_reg || prev_reg < level_reg))
                begin
                    state_next = ST_HEMIT;
                end
                else
                begin
                    prev_next       = cur_byte;
                    prev_valid_next = 1'b1;
                    if (ptr_reg == LAST_BYTE)
                    begin
                        hunt_next  = hunt_reg + 8'd1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + BYTE_IDX_W'(1);
                    end
                end
            end

            ST_HEMIT:
            begin
                if (slot_free)
                begin
                    out_load                    = 1'b1;
                    out_data_next.kind          = KIND_SAMPLE;
                    out_data_next.sample_index  = 8'(pre_reg);
                    out_data_next.sample_code   = cur_byte - CODE_OFFSET;
                    out_data_next.last          = (hunt_ptr_sum >= 9'(FRAME_BYTES));
                    pre_next                    = pre_reg + 4'd1;
                    if (hunt_ptr_sum >= 9'(FRAME_BYTES))
                    begin
                        hunt_next  = hunt_reg + 8'd1;
                        phase_next = PH_CAPTURE;
                        fc_next    = '0;
                        df_next    = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next = hunt_ptr_sum[BYTE_IDX_W-1:0];
                    end
                end
            end

            ST_DIVA:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_r_next   = div_ge ? 5'(div_trial - {1'b0, div_d_reg}) : div_trial[4:0];
                    div_n_next   = {div_n_reg[DIV_W-2:0], div_ge};
                    div_cnt_next = div_cnt_reg - DCNT_W'(1);
                end
                else
                begin
                    fc_next     = fc_plus1[FC_W-1:0];
                    stride_next = stride_hit;
                    ptr_next    = '0;
                    if (small_reg)
                    begin
                        if (freq_reg)
                        begin
                            cnt_next   = '0;
                            done_next  = (q_plus_pre > LAST_SLOT) || stride_hit;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            // write position known, second pass for the fill
                            idx_next     = q_plus_pre;
                            cnt_next     = samples_per_frame(m_reg[2:0]);
                            df_next      = df_plus1[7:0];
                            div_n_next   = DIV_W'({df_plus1, 3'b000});
                            div_r_next   = '0;
                            div_cnt_next = DCNT_W'(DIV_W);
                            state_next   = ST_DIVB;
                        end
                    end
                    else
                    begin
                        idx_next   = big_idx;
                        cnt_next   = (big_hit && big_idx <= LAST_SLOT) ? 4'd1 : 4'd0;
                        done_next  = (big_fill > LAST_SLOT) || stride_hit;
                        df_next    = df_sum[7:0];
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_DIVB:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_r_next   = div_ge ? 5'(div_trial - {1'b0, div_d_reg}) : div_trial[4:0];
                    div_n_next   = {div_n_reg[DIV_W-2:0], div_ge};
                    div_cnt_next = div_cnt_reg - DCNT_W'(1);
                end
                else
                begin
                    done_next  = (q_plus_pre > LAST_SLOT) || stride_reg;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (freq_reg)
                begin
                    if (slot_free)
                    begin
                        out_load                      = 1'b1;
                        out_data_next.kind            = KIND_FREQ;
                        out_data_next.frequency_value = {frame_reg[5], frame_reg[6], frame_reg[7]};
                        out_data_next.last            = !done_reg;
                        state_next                    = done_reg ? ST_DONE : ST_IDLE;
                    end
                end
                else if (cnt_reg != '0 && idx_reg <= LAST_SLOT)
                begin
                    if (slot_free)
                    begin
                        out_load                   = 1'b1;
                        out_data_next.kind         = KIND_SAMPLE;
                        out_data_next.sample_index = idx_reg[7:0];
                        out_data_next.sample_code  = cur_byte - CODE_OFFSET;
                        out_data_next.last         = !done_reg &&
                                                     (cnt_reg == 4'd1 || idx_reg >= LAST_SLOT);
                        ptr_next                   = ptr_reg + m_reg[BYTE_IDX_W-1:0];
                        idx_next                   = idx_reg + IDX_W'(1);
                        cnt_next                   = cnt_reg - 4'd1;
                    end
                end
                else
                begin
                    state_next = done_reg ? ST_DONE : ST_IDLE;
                end
            end

            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_load                  = 1'b1;
                    out_data_next.kind        = KIND_DONE;
                    out_data_next.frames_used = df_reg;
                    out_data_next.last        = 1'b1;
                    phase_next                = PH_IDLE;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_IDLE;
            prev_valid_reg <= 1'b0;
            hunt_reg       <= '0;
            pre_reg        <= '0;
            fc_reg         <= '0;
            df_reg         <= '0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            prev_valid_reg <= prev_valid_next;
            hunt_reg       <= hunt_next;
            pre_reg        <= pre_next;
            fc_reg         <= fc_next;
            df_reg         <= df_next;
            div_cnt_reg    <= div_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        prev_reg   <= prev_next;
        m_reg      <= m_next;
        freq_reg   <= freq_next;
        small_reg  <= small_next;
        ptr_reg    <= ptr_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        stride_reg <= stride_next;
        done_reg   <= done_next;
        div_n_reg  <= div_n_next;
        div_r_reg  <= div_r_next;
        div_d_reg  <= div_d_next;
        if (cmd_fire)
        begin
            frame_reg[0] <= cmd.data.byte_0;
            frame_reg[1] <= cmd.data.byte_1;
            frame_reg[2] <= cmd.data.byte_2;
            frame_reg[3] <= cmd.data.byte_3;
            frame_reg[4] <= cmd.data.byte_4;
            frame_reg[5] <= cmd.data.byte_5;
            frame_reg[6] <= cmd.data.byte_6;
            frame_reg[7] <= cmd.data.byte_7;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // a done item always closes the results of its frame
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.kind == KIND_DONE |-> result.data.last)
        else $error("done item without last");

    // no sample lands outside the capture buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.kind == KIND_SAMPLE |->
            result.data.sample_index <= 8'(CAPTURE_DEPTH - 1))
        else $error("sample index beyond capture buffer");

    // the shared divider never runs on a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVA || state_reg == ST_DIVB) |-> div_d_reg != '0)
        else $error("divider started with zero divisor");

    // a frame taken while no capture is armed leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && cmd.data.opcode == OP_FRAME && phase_reg == PH_IDLE |=>
            state_reg == ST_IDLE && !$rose(out_valid_reg))
        else $error("idle frame started work");
`endif

endmodule

@@ test/edge_triggered_decimating_capture_core_test.sv @@
// self-checking testbench for edge_triggered_decimating_capture_core: directed and random
// arm commands and adc frames, every result checked in order against a built-in predictor
// depends on etdc_pkg, etdc_in_if, etdc_out_if and the core
module edge_triggered_decimating_capture_core_test;
    import etdc_pkg::*;

    localparam int TOTAL_ITEMS   = 350;
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int SETTLE_CYCLES = 100;    // covers the slowest capture frame with margin
    localparam int QUIET_LIMIT   = 10000;  // cycles without any transfer before giving up
    localparam int LAST_INDEX    = CAPTURE_DEPTH_DEF - 1;

    // receiver stall patterns
    typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = REG_LEVEL;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 offer_valid = 1'b0;
    etdc_in_t             offer_item  = '0;
    logic                 take_ready  = 1'b0;

    etdc_in_if  cmd_ch ();
    etdc_out_if res_ch ();

    assign cmd_ch.valid = offer_valid;
    assign cmd_ch.data  = offer_item;
    assign res_ch.ready = take_ready;

    edge_triggered_decimating_capture_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .result    (res_ch)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // capture predictor: register copies and capture state
    // ------------------------------------------------------------------
    logic [7:0] level_reg   = LEVEL_RST;
    logic [7:0] stride_reg  = DECIM_RST;
    logic [7:0] timeout_reg = TIMEOUT_RST;
    logic [1:0] cap_phase   = PH_IDLE;
    int         prev_byte   = -1;      // -1 stands below any level
    int         hunt_count  = 0;
    int         pre_count   = 0;       // samples written by the trigger frame
    int         frame_count = 0;       // capture frames including frequency frames
    int         data_count  = 0;       // frames that advanced the write position

    etdc_out_t  pending_results [$];   // expected results, oldest first
    etdc_in_t   stim_queue [$];        // items waiting for the driver

    int items_queued = 0;
    int items_taken  = 0;
    int items_made   = 0;
    int error_count  = 0;

    function automatic etdc_out_t sample_result(int idx, logic [7:0] raw);
        etdc_out_t r;
        r              = '0;
        r.kind         = KIND_SAMPLE;
        r.sample_index = 8'(idx);
        r.sample_code  = raw - CODE_OFFSET;
        return r;
    endfunction

    // works out the results of one accepted item and queues them
    function automatic void predict_capture(etdc_in_t it);
        logic [7:0] b [FRAME_BYTES];
        etdc_out_t  res [$];
        etdc_out_t  r;
        int         m;
        int         idx;
        int         fill;
        bit         hit;
        b[0] = it.byte_0;
        b[1] = it.byte_1;
        b[2] = it.byte_2;
        b[3] = it.byte_3;
        b[4] = it.byte_4;
        b[5] = it.byte_5;
        b[6] = it.byte_6;
        b[7] = it.byte_7;
        hit  = 1'b0;

        // arm restarts everything, even mid-capture
        if (it.opcode == OP_ARM) begin
            cap_phase   = PH_HUNT;
            prev_byte   = -1;
            hunt_count  = 0;
            pre_count   = 0;
            frame_count = 0;
            data_count  = 0;
            return;
        end
        // frames while idle are dropped
        if (cap_phase != PH_HUNT && cap_phase != PH_CAPTURE)
            return;

        // zero stride behaves as one
        m = (stride_reg == 8'd0) ? 1 : int'(stride_reg);

        if (cap_phase == PH_HUNT) begin
            if (hunt_count >= int'(timeout_reg)) begin
                // hunt gave up: this frame only opens the capture
                hit = 1'b1;
            end
            else begin
                for (int i = 0; i < FRAME_BYTES && !hit; i++) begin
                    if (b[i] >= level_reg && prev_byte < int'(level_reg)) begin
                        for (int p = i; p < FRAME_BYTES; p += m) begin
                            res.push_back(sample_result(pre_count, b[p]));
                            pre_count++;
                        end
                        hit = 1'b1;
                    end
                    else
                        prev_byte = int'(b[i]);
                end
                hunt_count++;
            end
            if (hit) begin
                cap_phase   = PH_CAPTURE;
                frame_count = 0;
                data_count  = 0;
            end
        end
        else begin
            if ({b[0], b[1], b[2], b[3]} == 32'h0) begin
                r                 = '0;
                r.kind            = KIND_FREQ;
                r.frequency_value = {b[5], b[6], b[7]};
                res.push_back(r);
            end
            else if (m < 8) begin
                idx = data_count * 8 / m + pre_count;
                for (int i = 0; i < 8 / m && idx <= LAST_INDEX; i++) begin
                    res.push_back(sample_result(idx, b[(m * i) % FRAME_BYTES]));
                    idx++;
                end
                data_count++;
            end
            else if (frame_count % (m / 8) == 0) begin
                idx = data_count + pre_count;
                if (idx <= LAST_INDEX)
                    res.push_back(sample_result(idx, b[0]));
                data_count++;
            end
            frame_count++;
            fill = (m < 8) ? data_count * 8 / m + pre_count : data_count + pre_count;
            if (fill > LAST_INDEX || frame_count >= FRAMES_PER_STRIDE_DEF * m) begin
                r             = '0;
                r.kind        = KIND_DONE;
                r.frames_used = 8'(data_count);
                res.push_back(r);
                cap_phase     = PH_IDLE;
            end
        end

        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[k])
            pending_results.push_back(res[k]);
    endfunction

    function automatic void compare_field(string field, logic [23:0] want, logic [23:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_result(etdc_out_t got);
        etdc_out_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual 0x%0h",
                     $time, got);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("kind",            24'(want.kind),            24'(got.kind));
        compare_field("sample_index",    24'(want.sample_index),    24'(got.sample_index));
        compare_field("sample_code",     24'(8'(want.sample_code)), 24'(8'(got.sample_code)));
        compare_field("frequency_value", want.frequency_value,      got.frequency_value);
        compare_field("frames_used",     24'(want.frames_used),     24'(got.frames_used));
        compare_field("last",            24'(want.last),            24'(got.last));
    endfunction

    // ------------------------------------------------------------------
    // sender: bursts of random length, random gaps in between
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk) begin
        if (!rst_n)
            offer_valid <= 1'b0;
        else if (!offer_valid || cmd_ch.ready) begin
            // slot is free: nothing offered, or the offered item was transferred now
            if (gap_left > 0) begin
                gap_left    <= gap_left - 1;
                offer_valid <= 1'b0;
            end
            else if (stim_queue.size() > 0) begin
                offer_item  <= stim_queue.pop_front();
                offer_valid <= 1'b1;
                if (burst_left <= 1) begin
                    // end of burst; a quarter of the bursts run straight on
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                offer_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // receiver: changing stall patterns plus a requested long hold-off
    // ------------------------------------------------------------------
    int          hold_request = 0;
    int          hold_seen    = 0;
    int          hold_left    = 0;
    rx_pattern_t rx_mode      = RX_STEADY;
    int          rx_mode_left = 0;
    int          rx_tick      = 0;

    always @(posedge clk) begin
        rx_tick <= rx_tick + 1;
        if (hold_seen != hold_request) begin
            // hold-off counted here, the sender keeps offering meanwhile
            hold_seen  <= hold_request;
            hold_left  <= HOLD_CYCLES;
            take_ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            take_ready <= 1'b0;
        end
        else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= rx_pattern_t'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(20, 200);
            end
            else
                rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                RX_STEADY: take_ready <= 1'b1;
                RX_COIN:   take_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: take_ready <= (rx_tick % 4 == 0);
                default:   take_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on every command transfer, check every result transfer
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                predict_capture(cmd_ch.data);
                items_taken++;
            end
            if (res_ch.valid && res_ch.ready)
                check_result(res_ch.data);
        end
    end

    // watchdog on transfers of either channel
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_LEVEL:   level_reg   = value;
            REG_DECIM:   stride_reg  = value;
            REG_TIMEOUT: timeout_reg = value;
            default:     ;
        endcase
    endtask

    // wait until everything sent is transferred and every result is in,
    // then give the block time to finish items that produce nothing
    task automatic drain_block();
        while (items_taken != items_queued || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void queue_item(etdc_in_t it, bit counted);
        stim_queue.push_back(it);
        items_queued++;
        if (counted)
            items_made++;
    endfunction

    function automatic etdc_in_t frame_of(logic [63:0] bytes);
        return {OP_FRAME, bytes};
    endfunction

    // payload of an arm command is don't-care, so it is random
    function automatic etdc_in_t arm_command();
        return {OP_ARM, 32'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [7:0] under_level();
        if (level_reg == 8'd0)
            return 8'($urandom);
        return 8'($urandom_range(0, int'(level_reg) - 1));
    endfunction

    // every byte below the level, so the hunt goes on
    function automatic etdc_in_t quiet_frame();
        logic [63:0] bytes;
        for (int i = 0; i < FRAME_BYTES; i++)
            bytes[63 - 8 * i -: 8] = under_level();
        return frame_of(bytes);
    endfunction

    // rising crossing at a random byte position
    function automatic etdc_in_t crossing_frame();
        logic [63:0] bytes;
        int          k;
        bytes = {32'($urandom), 32'($urandom)};
        k     = $urandom_range(0, FRAME_BYTES - 1);
        for (int i = 0; i < k; i++)
            bytes[63 - 8 * i -: 8] = under_level();
        bytes[63 - 8 * k -: 8] = 8'($urandom_range(int'(level_reg), 255));
        return frame_of(bytes);
    endfunction

    // capture data: mostly random, some frequency frames and extreme bytes
    function automatic etdc_in_t capture_frame();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return frame_of({32'h0, 32'($urandom)});
        if (pick == 1)
            return frame_of(($urandom_range(0, 1) == 1) ? {8{8'hFF}} :
                            {8'h80, 8'h7F, 8'h01, 8'hFE, 8'h00, 8'hFF, 8'h80, 8'h7F});
        return frame_of({32'($urandom), 32'($urandom)});
    endfunction

    logic [7:0] stride_choices [16] = '{1, 1, 1, 2, 2, 4, 3, 5, 6, 7, 0, 8, 16, 24, 128, 9};

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase_no;
        int m_eff;
        int run_len;
        int split;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, level 128, stride 1, timeout 120
        queue_item(frame_of(64'hFF00_FF00_807F_01FE), 1);  // dropped, block idle
        queue_item(arm_command(), 1);
        // frequency-shaped frame while hunting is searched like any other
        queue_item(frame_of(64'h0000_0000_1122_3344), 1);
        queue_item(frame_of(64'h0010_207F_80FF_9001), 1);  // crossing at byte 4
        queue_item(frame_of(64'h0000_0000_AAFF_FFFF), 1);  // largest frequency
        queue_item(frame_of(64'h0000_0000_0000_0000), 1);  // zero frequency
        queue_item(frame_of({8{8'hFF}}), 1);
        queue_item(frame_of(64'h0080_7F01_FE00_FF80), 1);
        // re-arm mid-capture; first byte at the level triggers at once
        queue_item(arm_command(), 1);
        queue_item(frame_of(64'h8000_0000_0000_0000), 1);
        queue_item(frame_of(64'h7F80_0102_0304_0506), 1);
        drain_block();

        // odd stride, lowest level, short timeout
        write_register(REG_DECIM, 8'd3);
        write_register(REG_LEVEL, 8'd0);
        write_register(REG_TIMEOUT, 8'd2);
        queue_item(arm_command(), 1);
        queue_item(frame_of({32'($urandom), 32'($urandom)}), 1);
        queue_item(capture_frame(), 1);
        queue_item(capture_frame(), 1);
        drain_block();

        // zero stride acts as one; zero timeout ends the hunt on the first frame
        write_register(REG_DECIM, 8'd0);
        write_register(REG_TIMEOUT, 8'd0);
        write_register(REG_LEVEL, 8'd255);
        queue_item(arm_command(), 1);
        queue_item(frame_of({8{8'hFF}}), 1);
        queue_item(capture_frame(), 1);
        queue_item(capture_frame(), 1);
        drain_block();

        // wide stride: only every second frame writes byte 0, frequency frames count
        write_register(REG_DECIM, 8'd16);
        write_register(REG_TIMEOUT, 8'd1);
        write_register(REG_LEVEL, 8'd200);
        queue_item(arm_command(), 1);
        queue_item(quiet_frame(), 1);
        queue_item(quiet_frame(), 1);                       // hunt times out
        queue_item(frame_of(64'h0000_0000_0012_3456), 1);
        queue_item(frame_of(64'h0102_0304_0506_0708), 1);
        queue_item(frame_of(64'hFE02_0304_0506_0708), 1);

        // random captures
        phase_no = 0;
        while (items_made < TOTAL_ITEMS) begin
            // sender pauses until every result of the last phase is in
            drain_block();
            if (phase_no == 0) begin
                write_register(REG_LEVEL, 8'd255);
                write_register(REG_DECIM, 8'd128);
                write_register(REG_TIMEOUT, 8'd255);
            end
            else if (phase_no == 1) begin
                write_register(REG_LEVEL, 8'd0);
                write_register(REG_DECIM, 8'd1);
                write_register(REG_TIMEOUT, 8'd0);
            end
            else if (phase_no == 2) begin
                write_register(REG_LEVEL, LEVEL_RST);
                write_register(REG_DECIM, DECIM_RST);
                write_register(REG_TIMEOUT, TIMEOUT_RST);
            end
            else if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 7))
                    0:       write_register(REG_LEVEL, 8'd0);
                    1:       write_register(REG_LEVEL, 8'd255);
                    default: write_register(REG_LEVEL, 8'($urandom));
                endcase
                write_register(REG_DECIM, stride_choices[$urandom_range(0, 15)]);
                write_register(REG_TIMEOUT, ($urandom_range(0, 3) == 0) ?
                               8'($urandom_range(0, 3)) : 8'($urandom_range(4, 255)));
            end

            // noise: a stray frame ahead of the arm, block usually idle
            if ($urandom_range(0, 5) == 0)
                queue_item(capture_frame(), 1'b0);

            queue_item(arm_command(), 1);
            if (timeout_reg <= 8'd3 && $urandom_range(0, 1) == 1) begin
                // hunt runs into the timeout
                repeat (int'(timeout_reg) + 1) queue_item(quiet_frame(), 1);
            end
            else begin
                repeat ($urandom_range(0, 3)) queue_item(quiet_frame(), 1);
                if ($urandom_range(0, 5) == 0)
                    queue_item(capture_frame(), 1);
                queue_item(crossing_frame(), 1);
            end

            m_eff = (stride_reg == 8'd0) ? 1 : int'(stride_reg);
            if (m_eff <= 2 && $urandom_range(0, 1) == 1)
                run_len = FRAMES_PER_STRIDE_DEF * m_eff + 1;   // runs the buffer full
            else
                run_len = $urandom_range(1, 20);

            if (phase_no == 2) begin
                // long hold-off while a full capture streams in
                run_len = FRAMES_PER_STRIDE_DEF + 1;
                hold_request++;
            end

            if (phase_no > 2 && $urandom_range(0, 5) == 0) begin
                // stride changed between frames of a running capture
                split = $urandom_range(1, run_len);
                repeat (split) queue_item(capture_frame(), 1);
                drain_block();
                write_register(REG_DECIM, stride_choices[$urandom_range(0, 15)]);
                repeat (run_len - split + 1) queue_item(capture_frame(), 1);
            end
            else
                repeat (run_len) queue_item(capture_frame(), 1);

            phase_no++;
        end

        drain_block();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
